@@ src/bitmap_run_allocator_core_assert.svh @@
// ----------------------------------------------------------------------------
// Bitmap run allocator assertion macros
// Shared concurrent assertion forms, clocked on clock, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef BITMAP_RUN_ALLOCATOR_CORE_ASSERT_SVH
`define BITMAP_RUN_ALLOCATOR_CORE_ASSERT_SVH

// Same-cycle implication.
`define BRA_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define BRA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/bra_pkg.sv @@
// ----------------------------------------------------------------------------
// Bitmap run allocator package
// Command codes, controller states and the controller/datapath link types.
// ----------------------------------------------------------------------------
package bra_pkg;

   localparam logic [7:0] MAP_BYTES_RESET = 8'd128;

   typedef enum logic [1:0] {
      CMD_CLEAR = 2'd0,
      CMD_TEST  = 2'd1,
      CMD_WRITE = 2'd2,
      CMD_FIND  = 2'd3
   } cmd_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_CLEAR,
      ST_TEST_RD,
      ST_TEST,
      ST_WRITE_RD,
      ST_WRITE,
      ST_FIND,
      ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      DP_IDLE,
      DP_INIT,
      DP_CLEAR,
      DP_READ,
      DP_TEST,
      DP_WRITE,
      DP_FIND
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      load;   // latch request word, reset per-item state
      logic      post;   // move result into output register
   } ctl_cmd_type;

   typedef struct packed {
      cmd_type req_cmd;
      logic    req_idx_ok;
      logic    req_len_bad;
      logic    init_last;
      logic    clear_last;
      logic    scan_done;
      logic    out_free;
   } dp_status_type;

endpackage

@@ src/bra_ctrl.sv @@
// ----------------------------------------------------------------------------
// Bitmap run allocator controller
// Sequences reset sweep, clear, test, write and run search over the datapath.
// ----------------------------------------------------------------------------
`include "bitmap_run_allocator_core_assert.svh"

module bra_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  bra_pkg::dp_status_type status,
   output bra_pkg::ctl_cmd_type   ctl
);

   bra_pkg::state_type state_ff;
   bra_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bra_pkg::ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bra_pkg::ST_INIT: begin
            if (status.init_last) state_in = bra_pkg::ST_IDLE;
         end
         bra_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               case (status.req_cmd)
                  bra_pkg::CMD_CLEAR: state_in = bra_pkg::ST_CLEAR;
                  bra_pkg::CMD_TEST: begin
                     state_in = status.req_idx_ok ? bra_pkg::ST_TEST_RD : bra_pkg::ST_DONE;
                  end
                  bra_pkg::CMD_WRITE: begin
                     state_in = status.req_idx_ok ? bra_pkg::ST_WRITE_RD : bra_pkg::ST_DONE;
                  end
                  bra_pkg::CMD_FIND: begin
                     state_in = status.req_len_bad ? bra_pkg::ST_DONE : bra_pkg::ST_FIND;
                  end
                  default: state_in = bra_pkg::ST_DONE;
               endcase
            end
         end
         bra_pkg::ST_CLEAR: begin
            if (status.clear_last) state_in = bra_pkg::ST_DONE;
         end
         bra_pkg::ST_TEST_RD:  state_in = bra_pkg::ST_TEST;
         bra_pkg::ST_TEST:     state_in = bra_pkg::ST_DONE;
         bra_pkg::ST_WRITE_RD: state_in = bra_pkg::ST_WRITE;
         bra_pkg::ST_WRITE:    state_in = bra_pkg::ST_DONE;
         bra_pkg::ST_FIND: begin
            if (status.scan_done) state_in = bra_pkg::ST_DONE;
         end
         bra_pkg::ST_DONE: begin
            if (status.out_free) state_in = bra_pkg::ST_IDLE;
         end
         default: state_in = bra_pkg::ST_INIT;
      endcase
   end

   // Outputs
   always_comb begin
      ctl.op     = bra_pkg::DP_IDLE;
      ctl.load   = 1'b0;
      ctl.post   = 1'b0;
      req_tready = 1'b0;
      case (state_ff)
         bra_pkg::ST_INIT:     ctl.op = bra_pkg::DP_INIT;
         bra_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            ctl.load   = req_tvalid;
         end
         bra_pkg::ST_CLEAR:    ctl.op = bra_pkg::DP_CLEAR;
         bra_pkg::ST_TEST_RD:  ctl.op = bra_pkg::DP_READ;
         bra_pkg::ST_TEST:     ctl.op = bra_pkg::DP_TEST;
         bra_pkg::ST_WRITE_RD: ctl.op = bra_pkg::DP_READ;
         bra_pkg::ST_WRITE:    ctl.op = bra_pkg::DP_WRITE;
         bra_pkg::ST_FIND:     ctl.op = bra_pkg::DP_FIND;
         bra_pkg::ST_DONE:     ctl.post = status.out_free;
         default:              ctl.op = bra_pkg::DP_IDLE;
      endcase
   end

   `BRA_ASSERT_NEXT(a_scan_ends, (state_ff == bra_pkg::ST_FIND) && status.scan_done, state_ff == bra_pkg::ST_DONE, "search end did not lead to result")
   `BRA_ASSERT_IMPLIES(a_post_free, ctl.post, status.out_free, "result posted over a held word")

endmodule

@@ src/bra_dp.sv @@
// ----------------------------------------------------------------------------
// Bitmap run allocator datapath
// Map store, byte pointer, run counter, result and output registers.
// ----------------------------------------------------------------------------
`include "bitmap_run_allocator_core_assert.svh"

module bra_dp #(
   parameter int unsigned MAX_BYTES = 128
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [1:0]             req_tuser,
   input  logic [23:0]            req_tdata,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [7:0]             csr_data,
   input  logic                   rsp_tready,
   output logic                   rsp_tvalid,
   output logic [15:0]            rsp_tdata,
   input  bra_pkg::ctl_cmd_type   ctl,
   output bra_pkg::dp_status_type status
);

   localparam int unsigned AW  = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
   localparam int unsigned PW  = $clog2(MAX_BYTES + 1);
   localparam int unsigned CAP = (MAX_BYTES > 255) ? 255 : MAX_BYTES;
   localparam logic [7:0]    CAP_B    = CAP[7:0];
   localparam logic [PW-1:0] LAST_PTR = PW'(MAX_BYTES - 1);

   logic [7:0]    map_bytes_ff, map_bytes_in;
   logic [7:0]    nbytes;
   logic [10:0]   nbits;
   logic [PW-1:0] nb_ptr;

   logic [9:0]    req_idx;
   logic          req_val;
   logic [10:0]   req_len;
   logic [9:0]    idx_ff;
   logic          val_ff;
   logic [10:0]   len_ff;

   logic [PW-1:0] ptr_ff, ptr_in;
   logic          pend_ff, pend_in;
   logic [7:0]    pbyte_ff;
   logic [10:0]   run_ff, run_in;
   logic          issue;

   logic [10:0]   run_v;
   logic          hit_v;
   logic [10:0]   start_v;

   logic          res_found_ff;
   logic [9:0]    res_start_ff;
   logic          res_state_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [15:0]   rsp_data_ff;

   logic [7:0]    mem [MAX_BYTES];
   logic [7:0]    rd_data_ff;
   logic          mem_we, mem_re;
   logic [AW-1:0] mem_addr;
   logic [7:0]    mem_wdata;
   logic [7:0]    bit_mask;

   assign req_idx = req_tdata[9:0];
   assign req_val = req_tdata[10];
   assign req_len = req_tdata[21:11];

   // Active map size, clamped to the store
   assign nbytes = (map_bytes_ff > CAP_B) ? CAP_B : map_bytes_ff;
   assign nbits  = {nbytes, 3'b000};
   assign nb_ptr = PW'(nbytes);

   assign csr_ready    = 1'b1;
   assign map_bytes_in = csr_valid ? csr_data : map_bytes_ff;

   assign issue = (ctl.op == bra_pkg::DP_FIND) && (ptr_ff < nb_ptr);

   // Byte pointer for sweeps and search
   always_comb begin
      ptr_in = ptr_ff;
      case (ctl.op)
         bra_pkg::DP_INIT:  ptr_in = (ptr_ff == LAST_PTR) ? '0 : ptr_ff + 1'b1;
         bra_pkg::DP_CLEAR: if (ptr_ff < nb_ptr) ptr_in = ptr_ff + 1'b1;
         bra_pkg::DP_FIND:  if (issue) ptr_in = ptr_ff + 1'b1;
         default:           ptr_in = ptr_ff;
      endcase
      if (ctl.load) ptr_in = '0;
   end

   // Walk the eight bits of the byte read last cycle
   always_comb begin
      run_v   = run_ff;
      hit_v   = 1'b0;
      start_v = '0;
      for (int b = 0; b < 8; b++) begin
         if (!hit_v) begin
            if (rd_data_ff[b]) begin
               run_v = '0;
            end else begin
               run_v = run_v + 11'd1;
               if (run_v == len_ff) begin
                  hit_v   = 1'b1;
                  start_v = {pbyte_ff, 3'(b)} + 11'd1 - len_ff;
               end
            end
         end
      end
   end

   assign pend_in = ctl.load ? 1'b0 : issue;
   assign run_in  = ctl.load ? '0 :
                    ((ctl.op == bra_pkg::DP_FIND) && pend_ff) ? run_v : run_ff;

   // Memory port
   assign bit_mask = 8'b1 << idx_ff[2:0];

   always_comb begin
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_addr  = ptr_ff[AW-1:0];
      mem_wdata = '0;
      case (ctl.op)
         bra_pkg::DP_INIT:  mem_we = 1'b1;
         bra_pkg::DP_CLEAR: mem_we = (ptr_ff < nb_ptr);
         bra_pkg::DP_READ: begin
            mem_re   = 1'b1;
            mem_addr = AW'(idx_ff[9:3]);
         end
         bra_pkg::DP_WRITE: begin
            mem_we    = 1'b1;
            mem_addr  = AW'(idx_ff[9:3]);
            mem_wdata = val_ff ? (rd_data_ff | bit_mask) : (rd_data_ff & ~bit_mask);
         end
         bra_pkg::DP_FIND:  mem_re = issue;
         default:           mem_re = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_addr] <= mem_wdata;
      if (mem_re) rd_data_ff <= mem[mem_addr];
   end

   assign rsp_valid_in = ctl.post ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         map_bytes_ff <= bra_pkg::MAP_BYTES_RESET;
         ptr_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         map_bytes_ff <= map_bytes_in;
         ptr_ff       <= ptr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      run_ff <= run_in;
      if (issue) pbyte_ff <= 8'(ptr_ff);
      if (ctl.load) begin
         idx_ff       <= req_idx;
         val_ff       <= req_val;
         len_ff       <= req_len;
         res_found_ff <= 1'b0;
         res_start_ff <= '0;
         res_state_ff <= 1'b0;
      end else begin
         if (ctl.op == bra_pkg::DP_TEST) res_state_ff <= rd_data_ff[idx_ff[2:0]];
         if ((ctl.op == bra_pkg::DP_FIND) && pend_ff && hit_v) begin
            res_found_ff <= 1'b1;
            res_start_ff <= start_v[9:0];
         end
      end
      if (ctl.post) rsp_data_ff <= {4'b0000, res_state_ff, res_start_ff, res_found_ff};
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Status toward the controller
   always_comb begin
      status.req_cmd     = bra_pkg::cmd_type'(req_tuser);
      status.req_idx_ok  = ({1'b0, req_idx} < nbits);
      status.req_len_bad = (req_len == 11'd0) || (req_len > nbits);
      status.init_last   = (ptr_ff == LAST_PTR);
      status.clear_last  = ({1'b0, ptr_ff} + 1'b1) >= {1'b0, nb_ptr};
      status.scan_done   = pend_ff && (hit_v || (({1'b0, pbyte_ff} + 9'd1) == {1'b0, nbytes}));
      status.out_free    = !rsp_valid_ff || rsp_tready;
   end

   `BRA_ASSERT_IMPLIES(a_found_no_bit, rsp_valid_ff && rsp_data_ff[0], !rsp_data_ff[11], "found and bit state both set")
   `BRA_ASSERT_IMPLIES(a_run_bound, ctl.op == bra_pkg::DP_FIND, run_ff <= len_ff, "free run count passed wanted length")

endmodule

@@ src/bitmap_run_allocator_core.sv @@
// ----------------------------------------------------------------------------
// Bitmap run allocator core
// First-fit allocation bitmap, one bit per resource, 1 used and 0 free.
// ----------------------------------------------------------------------------
// Request words (req_) carry one command each: clear the active map, test bit,
// write bit or find the lowest run of run_length free bits. Every request
// returns one word on rsp_. csr_ writes map_bytes, the active map size in
// bytes; write it only while no request is in flight.
// Per request, from accept to result in the output register: test and write
// read the map byte, then test or update the bit; clear sweeps the active map;
// find reads one map byte per cycle from the store until a hit or the map end;
// a find with zero or oversize length, or an out-of-map index, skips to the result.
// One request is worked at a time; the next request is taken as soon as the
// controller is back in idle, even while the previous result waits.
// After reset the whole store, all MAX_BYTES bytes, is swept to zero, one byte
// a cycle; req_tready stays low during that sweep.
// A stalled rsp_tready holds the result word; a finished request then waits
// before posting, and no new request is taken until it has posted.
// ----------------------------------------------------------------------------
module bitmap_run_allocator_core #(
   parameter int unsigned MAX_BYTES = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // [1:0] cmd
   input  logic [23:0] req_tdata,   // [9:0] bit_index, [10] bit_value, [21:11] run_length
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [0] found, [10:1] start_index, [11] bit_state
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data     // map_bytes
);

   // Command and status link between the two halves
   bra_pkg::ctl_cmd_type   ctl;
   bra_pkg::dp_status_type status;

   // Sequence each request through its states
   bra_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .ctl        (ctl)
   );

   // Hold the map, the search counters and the result word
   bra_dp #(
      .MAX_BYTES (MAX_BYTES)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .ctl        (ctl),
      .status     (status)
   );

endmodule

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// Bitmap run allocator testbench
// Drives request words into the allocator core, mirrors the allocation map in
// a local model, and checks every reply word in order. A directed table covers
// the field extremes, map-size corners and out-of-map indexes. Phases of
// random traffic follow, each under a new map size, with bursty requests and
// a stalling reply side.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned MAP_CAP     = 128;   // store depth in bytes
   localparam int unsigned PHASE_ITEMS = 210;
   localparam int unsigned STALL_LIMIT = 4000;  // cycles with no handshake at all
   localparam int unsigned SETTLE      = 200;

   typedef struct packed {
      logic       found;
      logic [9:0] start_index;
      logic       bit_state;
   } reply_type;

   typedef struct packed {
      logic             csr_write;   // row rewrites map_bytes instead of sending a word
      logic [7:0]       csr_value;
      bra_pkg::cmd_type cmd;
      logic [9:0]       idx;
      logic             val;
      logic [10:0]      len;
      logic             fixed;       // reply typed in below, otherwise from the model
      reply_type        reply;
   } step_type;

   localparam reply_type QUIET      = '{1'b0, 10'd0, 1'b0};
   localparam reply_type BIT_SET    = '{1'b0, 10'd0, 1'b1};
   localparam reply_type FOUND_AT_0 = '{1'b1, 10'd0, 1'b0};
   localparam reply_type FOUND_AT_1 = '{1'b1, 10'd1, 1'b0};

   localparam step_type DIRECTED [29] = '{
      // fresh map, all free
      '{1'b0, 8'd0,   bra_pkg::CMD_TEST,  10'd0,    1'b0, 11'd0,    1'b1, QUIET},
      '{1'b0, 8'd0,   bra_pkg::CMD_TEST,  10'd1023, 1'b0, 11'd0,    1'b1, QUIET},
      '{1'b0, 8'd0,   bra_pkg::CMD_FIND,  10'd0,    1'b0, 11'd1024, 1'b1, FOUND_AT_0},
      '{1'b0, 8'd0,   bra_pkg::CMD_FIND,  10'd0,    1'b0, 11'd0,    1'b1, QUIET},
      '{1'b0, 8'd0,   bra_pkg::CMD_FIND,  10'd0,    1'b0, 11'd2047, 1'b1, QUIET},
      // mark both ends of the map
      '{1'b0, 8'd0,   bra_pkg::CMD_WRITE, 10'd0,    1'b1, 11'd0,    1'b1, QUIET},
      '{1'b0, 8'd0,   bra_pkg::CMD_WRITE, 10'd1023, 1'b1, 11'd0,    1'b1, QUIET},
      '{1'b0, 8'd0,   bra_pkg::CMD_TEST,  10'd0,    1'b0, 11'd0,    1'b1, BIT_SET},
      '{1'b0, 8'd0,   bra_pkg::CMD_FIND,  10'd0,    1'b0, 11'd1022, 1'b1, FOUND_AT_1},
      '{1'b0, 8'd0,   bra_pkg::CMD_FIND,  10'd0,    1'b0, 11'd1023, 1'b1, QUIET},
      '{1'b0, 8'd0,   bra_pkg::CMD_WRITE, 10'd5,    1'b1, 11'd0,    1'b1, QUIET},
      '{1'b0, 8'd0,   bra_pkg::CMD_FIND,  10'd0,    1'b0, 11'd5,    1'b0, QUIET},
      '{1'b0, 8'd0,   bra_pkg::CMD_CLEAR, 10'd0,    1'b0, 11'd0,    1'b1, QUIET},
      '{1'b0, 8'd0,   bra_pkg::CMD_TEST,  10'd1023, 1'b0, 11'd0,    1'b1, QUIET},
      // empty map: nothing changes, nothing found
      '{1'b1, 8'd0,   bra_pkg::CMD_CLEAR, 10'd0,    1'b0, 11'd0,    1'b0, QUIET},
      '{1'b0, 8'd0,   bra_pkg::CMD_WRITE, 10'd3,    1'b1, 11'd0,    1'b1, QUIET},
      '{1'b0, 8'd0,   bra_pkg::CMD_TEST,  10'd3,    1'b0, 11'd0,    1'b1, QUIET},
      '{1'b0, 8'd0,   bra_pkg::CMD_FIND,  10'd0,    1'b0, 11'd1,    1'b1, QUIET},
      '{1'b0, 8'd0,   bra_pkg::CMD_CLEAR, 10'd0,    1'b0, 11'd0,    1'b1, QUIET},
      // size above the store acts as the full store
      '{1'b1, 8'd255, bra_pkg::CMD_CLEAR, 10'd0,    1'b0, 11'd0,    1'b0, QUIET},
      '{1'b0, 8'd0,   bra_pkg::CMD_WRITE, 10'd1023, 1'b1, 11'd0,    1'b1, QUIET},
      '{1'b0, 8'd0,   bra_pkg::CMD_TEST,  10'd1023, 1'b0, 11'd0,    1'b0, QUIET},
      // one-byte map: clear touches byte 0 only, index 8 is outside
      '{1'b1, 8'd1,   bra_pkg::CMD_CLEAR, 10'd0,    1'b0, 11'd0,    1'b0, QUIET},
      '{1'b0, 8'd0,   bra_pkg::CMD_CLEAR, 10'd0,    1'b0, 11'd0,    1'b1, QUIET},
      '{1'b0, 8'd0,   bra_pkg::CMD_TEST,  10'd8,    1'b0, 11'd0,    1'b1, QUIET},
      '{1'b0, 8'd0,   bra_pkg::CMD_FIND,  10'd0,    1'b0, 11'd8,    1'b1, FOUND_AT_0},
      '{1'b0, 8'd0,   bra_pkg::CMD_FIND,  10'd0,    1'b0, 11'd9,    1'b1, QUIET},
      // back to full size: the top bit survived the small clear
      '{1'b1, 8'd128, bra_pkg::CMD_CLEAR, 10'd0,    1'b0, 11'd0,    1'b0, QUIET},
      '{1'b0, 8'd0,   bra_pkg::CMD_TEST,  10'd1023, 1'b0, 11'd0,    1'b0, QUIET}
   };

   localparam logic [7:0] PHASE_SIZES [8] = '{8'd16, 8'd2, 8'd128, 8'd0,
                                              8'd255, 8'd1, 8'd64, 8'd5};

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [1:0]  req_tuser  = '0;
   logic [23:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_data   = '0;

   // local copy of the allocation map and its active size
   logic [7:0]  alloc_map [MAP_CAP];
   int unsigned map_bytes_cfg = bra_pkg::MAP_BYTES_RESET;

   reply_type   pending_replies [$];
   int unsigned mismatches   = 0;
   int unsigned burst_left   = 0;
   int unsigned quiet_cycles = 0;
   int unsigned stall_mode   = 0;
   int unsigned stall_left   = 0;

   bitmap_run_allocator_core #(
      .MAX_BYTES(MAP_CAP)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),    // [1:0] cmd
      .req_tdata  (req_tdata),    // [9:0] bit_index, [10] bit_value, [21:11] run_length
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),    // [0] found, [10:1] start_index, [11] bit_state
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)      // map_bytes
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   initial begin
      foreach (alloc_map[b]) alloc_map[b] = '0;
   end

   // Apply one request to the local map and return the reply it must produce.
   function automatic reply_type allocator_reply(bra_pkg::cmd_type cmd, logic [9:0] idx,
                                                 logic val, logic [10:0] len);
      int unsigned nbytes;
      int unsigned nbits;
      int unsigned run;
      reply_type   r;
      nbytes = (map_bytes_cfg > MAP_CAP) ? MAP_CAP : map_bytes_cfg;
      nbits  = nbytes * 8;
      r      = QUIET;
      case (cmd)
         bra_pkg::CMD_CLEAR: begin
            for (int unsigned b = 0; b < nbytes; b++) alloc_map[b] = '0;
         end
         bra_pkg::CMD_TEST: begin
            if (idx < nbits) r.bit_state = alloc_map[idx[9:3]][idx[2:0]];
         end
         bra_pkg::CMD_WRITE: begin
            if (idx < nbits) alloc_map[idx[9:3]][idx[2:0]] = val;
         end
         bra_pkg::CMD_FIND: begin
            // first fit: lowest start of len free bits, kept inside the active map
            if (len != 0 && len <= nbits) begin
               run = 0;
               for (int unsigned i = 0; i < nbits; i++) begin
                  if (alloc_map[i / 8][i % 8]) begin
                     run = 0;
                  end else begin
                     run++;
                     if (run == len) begin
                        r.found       = 1'b1;
                        r.start_index = 10'(i + 1 - len);
                        break;
                     end
                  end
               end
            end
         end
         default: r = QUIET;
      endcase
      return r;
   endfunction

   // Present one request word, bursty, and log its reply once accepted.
   task automatic issue_request(bra_pkg::cmd_type cmd, logic [9:0] idx, logic val,
                                logic [10:0] len, logic fixed, reply_type fixed_reply);
      int unsigned gap;
      reply_type   predicted;
      if (burst_left == 0) begin
         gap        = $urandom_range(0, 12);
         burst_left = $urandom_range(1, 24);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {2'b00, len, val, idx};
      do @(posedge clock); while (!req_tready);
      predicted = allocator_reply(cmd, idx, val, len);
      pending_replies.push_back(fixed ? fixed_reply : predicted);
   endtask

   // Hold off the sender until every outstanding reply has come back.
   task automatic drain_replies();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_replies.size() != 0);
   endtask

   // Rewrite map_bytes with the block idle.
   task automatic set_map_bytes(logic [7:0] value);
      drain_replies();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid     <= 1'b0;
      map_bytes_cfg = value;
   endtask

   initial begin : stimulus
      int unsigned      nbits;
      int unsigned      pick;
      bra_pkg::cmd_type cmd;
      logic [9:0]       idx;
      logic             val;
      logic [10:0]      len;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[r]) begin
         if (DIRECTED[r].csr_write)
            set_map_bytes(DIRECTED[r].csr_value);
         else
            issue_request(DIRECTED[r].cmd, DIRECTED[r].idx, DIRECTED[r].val,
                          DIRECTED[r].len, DIRECTED[r].fixed, DIRECTED[r].reply);
      end

      // random phases, each under its own map size; the last size is random
      for (int unsigned phase = 0; phase < 9; phase++) begin
         set_map_bytes((phase < 8) ? PHASE_SIZES[phase] : 8'($urandom_range(0, 255)));
         nbits = ((map_bytes_cfg > MAP_CAP) ? MAP_CAP : map_bytes_cfg) * 8;
         for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 3)
               cmd = bra_pkg::CMD_CLEAR;
            else if (pick < 33)
               cmd = bra_pkg::CMD_TEST;
            else if (pick < 70)
               cmd = bra_pkg::CMD_WRITE;
            else
               cmd = bra_pkg::CMD_FIND;
            // mostly inside the active map, sometimes anywhere
            if (nbits == 0 || $urandom_range(0, 9) == 0)
               idx = 10'($urandom_range(0, 1023));
            else
               idx = 10'($urandom_range(0, nbits - 1));
            val = ($urandom_range(0, 99) < 55);
            case ($urandom_range(0, 19))
               0:       len = 11'($urandom_range(0, 2047));
               1:       len = '0;
               2:       len = 11'(nbits);
               3:       len = 11'($urandom_range(0, nbits + 1));
               default: len = 11'($urandom_range(1, 6));
            endcase
            issue_request(cmd, idx, val, len, 1'b0, QUIET);
            if ($urandom_range(0, 79) == 0) drain_replies();
         end
      end

      drain_replies();
      repeat (SETTLE) @(posedge clock);
      if (mismatches == 0 && pending_replies.size() == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end

   // Reply side: stall in stretches of random mode and length.
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = (stall_mode == 2) ? $urandom_range(1, 24) : $urandom_range(4, 60);
      end
      stall_left--;
      case (stall_mode)
         0:       rsp_tready <= 1'b1;
         1:       rsp_tready <= 1'($urandom_range(0, 1));
         2:       rsp_tready <= 1'b0;
         default: rsp_tready <= stall_left[0];
      endcase
   end

   // Compare each reply word against the oldest expectation.
   always @(posedge clock) begin : reply_check
      reply_type got;
      reply_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tdata[0], rsp_tdata[10:1], rsp_tdata[11]};
         if (pending_replies.size() == 0) begin
            mismatches++;
            $display({"%0t: reply word with none expected, expected no word,",
                      " got found=%0d start=%0d state=%0d"},
                     $time, got.found, got.start_index, got.bit_state);
         end else begin
            want = pending_replies.pop_front();
            if (got !== want) begin
               mismatches++;
               $display({"%0t: reply mismatch, expected found=%0d start=%0d state=%0d,",
                         " got found=%0d start=%0d state=%0d"}, $time,
                        want.found, want.start_index, want.bit_state,
                        got.found, got.start_index, got.bit_state);
            end
         end
      end
   end

   // Watchdog: end the run when no word moves on any channel for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("testbench: errors");
         $finish;
      end
   end

endmodule
